>>> rtl/kce_pkg.sv
// ----------------------------------------------------------------------------
// kce_pkg
// Shared constants, types and codes for the k-means clustering engine.
// ----------------------------------------------------------------------------
package kce_pkg;

    localparam int MAX_POINTS   = 1024;
    localparam int MAX_DIMS     = 8;
    localparam int MAX_CLUSTERS = 16;
    localparam int COORD_W      = 16;

    localparam int PIDX_W = $clog2(MAX_POINTS);
    localparam int DIDX_W = $clog2(MAX_DIMS);
    localparam int CIDX_W = $clog2(MAX_CLUSTERS);
    localparam int NPT_W  = PIDX_W + 1;
    localparam int NDIM_W = DIDX_W + 1;
    localparam int NCL_W  = CIDX_W + 1;
    localparam int ITER_W = 8;
    localparam int CNT_W  = NPT_W;
    localparam int SUM_W  = COORD_W + PIDX_W + 1;
    localparam int SQ_W   = 2 * (COORD_W + 1);
    localparam int DIST_W = SQ_W + DIDX_W;
    localparam int CFG_W  = NPT_W;
    localparam int CFGI_W = 2;

    typedef enum logic [1:0] {
        CMD_LOAD     = 2'd0,
        CMD_START    = 2'd1,
        CMD_RD_ASG   = 2'd2,
        CMD_RD_CENT  = 2'd3
    } cmd_t;

    typedef enum logic [CFGI_W-1:0] {
        REG_NUM_CLUSTERS   = 2'd0,
        REG_NUM_ITERATIONS = 2'd1,
        REG_NUM_POINTS     = 2'd2,
        REG_NUM_DIMS       = 2'd3
    } reg_idx_t;

    typedef logic [MAX_DIMS-1:0][COORD_W-1:0] coord_vec_t;
    typedef logic [MAX_DIMS-1:0][SUM_W-1:0]   sum_vec_t;

    typedef struct packed {
        logic                clr_sums;
        logic                acc_clr;
        logic                mul_en;
        logic                acc_en;
        logic [DIDX_W-1:0]   dim;
        logic [COORD_W-1:0]  x;
        logic                upd_en;
        logic [CIDX_W-1:0]   upd_idx;
        coord_vec_t          pt;
        logic                cw_en;
        logic [CIDX_W-1:0]   cw_idx;
        logic [DIDX_W-1:0]   cw_dim;
        logic [COORD_W-1:0]  cw_data;
        logic [NCL_W-1:0]    k;
        logic [NDIM_W-1:0]   d;
    } cell_ctrl_t;

    typedef struct packed {
        logic                valid;
        logic [DIST_W-1:0]   score;
        logic [CIDX_W-1:0]   idx;
    } cand_t;

endpackage

>>> rtl/kmeans_clustering_engine.sv
// ----------------------------------------------------------------------------
// kmeans_clustering_engine
// Lloyd k-means over a stored point set, one cell per cluster.
// ----------------------------------------------------------------------------
// Commands come in on the s_ channel, one result per command on the m_ channel.
// load and read-centroid results are registered directly; read-assignment
// goes through the registered memory read and ST_ARD. Back-to-back loads
// run at one per cycle while m_ready stays high. start seeds the k
// centroids from points 0 to k-1, then per iteration: for every point d
// rounds of read, square and accumulate (one multiplier per cell), a pass
// through the compare chain of 16 cells and an assignment update; then a
// check per cluster and d divisions per non-empty cluster in the shared divider.
// No new command is taken while start runs.
// After reset the whole assignment memory is cleared, one entry a cycle,
// during which s_ready stays low; configuration writes are
// taken at any time. Results sit in an output register; a stalled
// receiver holds m_valid and the payload, and the next command is taken
// in the same cycle the waiting result transfers.
// ----------------------------------------------------------------------------
module kmeans_clustering_engine
    import kce_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [CFGI_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_cmd,
    input  logic [PIDX_W-1:0]   s_point_index,
    input  logic [DIDX_W-1:0]   s_dim_index,
    input  logic [CIDX_W-1:0]   s_cluster_index,
    input  logic [COORD_W-1:0]  s_coord_in,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_result_kind,
    output logic [COORD_W-1:0]  m_coord_out,
    output logic [CIDX_W-1:0]   m_cluster_out
);

    typedef enum logic [3:0] {
        ST_CLR, ST_IDLE, ST_ARD, ST_SEED, ST_SEED_W, ST_ITER, ST_P_RD, ST_P_LD,
        ST_P_ACC, ST_CH_GO, ST_CH_WAIT, ST_UPD, ST_M_CHK, ST_M_GO, ST_M_WAIT,
        ST_DONE
    } state_t;

    localparam int PADDR_W = PIDX_W + DIDX_W;

    state_t               state_reg;
    logic [NCL_W-1:0]     num_clusters_reg;
    logic [ITER_W-1:0]    num_iterations_reg;
    logic [NPT_W-1:0]     num_points_reg;
    logic [NDIM_W-1:0]    num_dims_reg;
    logic [NCL_W-1:0]     k_reg;
    logic [NPT_W-1:0]     n_reg;
    logic [NDIM_W-1:0]    d_reg;
    logic [NCL_W-1:0]     c_reg;
    logic [NDIM_W-1:0]    j_reg;
    logic [NPT_W-1:0]     p_reg;
    logic [ITER_W-1:0]    it_reg;
    logic [CIDX_W-1:0]    best_reg;
    coord_vec_t           pbuf_reg;
    logic                 m_valid_reg;
    logic [1:0]           m_kind_reg;
    logic [COORD_W-1:0]   m_coord_reg;
    logic [CIDX_W-1:0]    m_cluster_reg;

    logic [COORD_W-1:0]   point_mem [MAX_POINTS*MAX_DIMS];
    logic [CIDX_W-1:0]    asg_mem [MAX_POINTS];
    logic [COORD_W-1:0]   pt_rd_reg;
    logic [CIDX_W-1:0]    asg_rd_reg;

    logic                 s_xfer;
    logic [PADDR_W-1:0]   pt_rd_addr;
    logic                 asg_we;
    logic [PIDX_W-1:0]    asg_waddr;
    logic [CIDX_W-1:0]    asg_wdata;
    logic [NPT_W-1:0]     n_clamp;
    logic [NDIM_W-1:0]    d_clamp;
    logic [NCL_W-1:0]     k_clamp;
    logic [NCL_W-1:0]     k_min;

    cell_ctrl_t           ctrl;
    cand_t                cand [MAX_CLUSTERS+1];
    coord_vec_t           cent_all [MAX_CLUSTERS];
    sum_vec_t             sum_all [MAX_CLUSTERS];
    logic [CNT_W-1:0]     cnt_all [MAX_CLUSTERS];
    logic [CNT_W-1:0]     cnt_sel;
    logic                 div_start;
    logic                 div_done;
    logic [COORD_W-1:0]   div_q;

    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign s_xfer  = s_valid && s_ready;

    // register clamps
    assign n_clamp = (num_points_reg == '0) ? NPT_W'(1) :
                     (num_points_reg > NPT_W'(MAX_POINTS)) ? NPT_W'(MAX_POINTS) :
                     num_points_reg;
    assign d_clamp = (num_dims_reg == '0) ? NDIM_W'(1) :
                     (num_dims_reg > NDIM_W'(MAX_DIMS)) ? NDIM_W'(MAX_DIMS) :
                     num_dims_reg;
    assign k_clamp = (num_clusters_reg == '0) ? NCL_W'(1) :
                     (num_clusters_reg > NCL_W'(MAX_CLUSTERS)) ? NCL_W'(MAX_CLUSTERS) :
                     num_clusters_reg;
    assign k_min   = ({{(NPT_W-NCL_W){1'b0}}, k_clamp} > n_clamp)
                     ? n_clamp[NCL_W-1:0] : k_clamp;

    assign pt_rd_addr = (state_reg == ST_SEED)
                      ? {{(PIDX_W-CIDX_W){1'b0}}, c_reg[CIDX_W-1:0], j_reg[DIDX_W-1:0]}
                      : {p_reg[PIDX_W-1:0], j_reg[DIDX_W-1:0]};

    always_ff @(posedge aclk) begin
        if (s_xfer && s_cmd == CMD_LOAD) begin
            point_mem[{s_point_index, s_dim_index}] <= s_coord_in;
        end
        pt_rd_reg <= point_mem[pt_rd_addr];
    end

    assign asg_we    = (state_reg == ST_CLR) || (state_reg == ST_UPD);
    assign asg_waddr = p_reg[PIDX_W-1:0];
    assign asg_wdata = (state_reg == ST_UPD) ? best_reg : '0;

    always_ff @(posedge aclk) begin
        if (asg_we) begin
            asg_mem[asg_waddr] <= asg_wdata;
        end
        asg_rd_reg <= asg_mem[s_point_index];
    end

    always_comb begin
        ctrl          = '0;
        ctrl.clr_sums = (state_reg == ST_ITER);
        ctrl.acc_clr  = (state_reg == ST_P_RD) && (j_reg == '0);
        ctrl.mul_en   = (state_reg == ST_P_LD);
        ctrl.acc_en   = (state_reg == ST_P_ACC);
        ctrl.dim      = j_reg[DIDX_W-1:0];
        ctrl.x        = pt_rd_reg;
        ctrl.upd_en   = (state_reg == ST_UPD);
        ctrl.upd_idx  = best_reg;
        ctrl.pt       = pbuf_reg;
        ctrl.cw_en    = (state_reg == ST_SEED_W) || (state_reg == ST_M_WAIT && div_done);
        ctrl.cw_idx   = c_reg[CIDX_W-1:0];
        ctrl.cw_dim   = j_reg[DIDX_W-1:0];
        ctrl.cw_data  = (state_reg == ST_SEED_W) ? pt_rd_reg : div_q;
        ctrl.k        = k_reg;
        ctrl.d        = d_reg;
    end

    assign cand[0].valid = (state_reg == ST_CH_GO);
    assign cand[0].score = '1;
    assign cand[0].idx   = '0;

    for (genvar i = 0; i < MAX_CLUSTERS; i++) begin : g_cell
        kce_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_id  (CIDX_W'(i)),
            .ctrl     (ctrl),
            .cand_in  (cand[i]),
            .cand_out (cand[i+1]),
            .cent     (cent_all[i]),
            .sums     (sum_all[i]),
            .count    (cnt_all[i])
        );
    end

    assign cnt_sel   = cnt_all[c_reg[CIDX_W-1:0]];
    assign div_start = (state_reg == ST_M_GO);

    kce_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_all[c_reg[CIDX_W-1:0]][j_reg[DIDX_W-1:0]]),
        .divisor  (cnt_sel),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_CLR;
            p_reg              <= '0;
            c_reg              <= '0;
            j_reg              <= '0;
            it_reg             <= '0;
            m_valid_reg        <= 1'b0;
            num_clusters_reg   <= NCL_W'(2);
            num_iterations_reg <= ITER_W'(10);
            num_points_reg     <= NPT_W'(1);
            num_dims_reg       <= NDIM_W'(2);
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_NUM_CLUSTERS:   num_clusters_reg   <= cfg_data[NCL_W-1:0];
                    REG_NUM_ITERATIONS: num_iterations_reg <= cfg_data[ITER_W-1:0];
                    REG_NUM_POINTS:     num_points_reg     <= cfg_data[NPT_W-1:0];
                    REG_NUM_DIMS:       num_dims_reg       <= cfg_data[NDIM_W-1:0];
                    default: ;
                endcase
            end
            case (state_reg)
                ST_CLR: begin
                    if (p_reg == NPT_W'(MAX_POINTS - 1)) begin
                        p_reg     <= '0;
                        state_reg <= ST_IDLE;
                    end else begin
                        p_reg <= p_reg + NPT_W'(1);
                    end
                end
                ST_IDLE: begin
                    if (s_xfer) begin
                        m_kind_reg    <= s_cmd;
                        m_coord_reg   <= '0;
                        m_cluster_reg <= '0;
                        case (s_cmd)
                            CMD_LOAD: begin
                                m_valid_reg <= 1'b1;
                            end
                            CMD_START: begin
                                n_reg     <= n_clamp;
                                d_reg     <= d_clamp;
                                k_reg     <= k_min;
                                c_reg     <= '0;
                                j_reg     <= '0;
                                state_reg <= ST_SEED;
                            end
                            CMD_RD_ASG: begin
                                state_reg <= ST_ARD;
                            end
                            default: begin
                                m_coord_reg <= cent_all[s_cluster_index][s_dim_index];
                                m_valid_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                ST_ARD: begin
                    m_cluster_reg <= asg_rd_reg;
                    m_valid_reg   <= 1'b1;
                    state_reg     <= ST_IDLE;
                end
                ST_SEED: begin
                    state_reg <= ST_SEED_W;
                end
                ST_SEED_W: begin
                    if (j_reg + NDIM_W'(1) == d_reg) begin
                        j_reg <= '0;
                        if (c_reg + NCL_W'(1) == k_reg) begin
                            it_reg    <= '0;
                            state_reg <= ST_ITER;
                        end else begin
                            c_reg     <= c_reg + NCL_W'(1);
                            state_reg <= ST_SEED;
                        end
                    end else begin
                        j_reg     <= j_reg + NDIM_W'(1);
                        state_reg <= ST_SEED;
                    end
                end
                ST_ITER: begin
                    if (it_reg == num_iterations_reg) begin
                        state_reg <= ST_DONE;
                    end else begin
                        p_reg     <= '0;
                        j_reg     <= '0;
                        state_reg <= ST_P_RD;
                    end
                end
                ST_P_RD: begin
                    state_reg <= ST_P_LD;
                end
                ST_P_LD: begin
                    pbuf_reg[j_reg[DIDX_W-1:0]] <= pt_rd_reg;
                    state_reg <= ST_P_ACC;
                end
                ST_P_ACC: begin
                    if (j_reg + NDIM_W'(1) == d_reg) begin
                        state_reg <= ST_CH_GO;
                    end else begin
                        j_reg     <= j_reg + NDIM_W'(1);
                        state_reg <= ST_P_RD;
                    end
                end
                ST_CH_GO: begin
                    state_reg <= ST_CH_WAIT;
                end
                ST_CH_WAIT: begin
                    if (cand[MAX_CLUSTERS].valid) begin
                        best_reg  <= cand[MAX_CLUSTERS].idx;
                        state_reg <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    j_reg <= '0;
                    if (p_reg + NPT_W'(1) == n_reg) begin
                        c_reg     <= '0;
                        state_reg <= ST_M_CHK;
                    end else begin
                        p_reg     <= p_reg + NPT_W'(1);
                        state_reg <= ST_P_RD;
                    end
                end
                ST_M_CHK: begin
                    j_reg <= '0;
                    if (c_reg == k_reg) begin
                        it_reg    <= it_reg + ITER_W'(1);
                        state_reg <= ST_ITER;
                    end else if (cnt_sel == '0) begin
                        c_reg <= c_reg + NCL_W'(1);
                    end else begin
                        state_reg <= ST_M_GO;
                    end
                end
                ST_M_GO: begin
                    state_reg <= ST_M_WAIT;
                end
                ST_M_WAIT: begin
                    if (div_done) begin
                        if (j_reg + NDIM_W'(1) == d_reg) begin
                            j_reg     <= '0;
                            c_reg     <= c_reg + NCL_W'(1);
                            state_reg <= ST_M_CHK;
                        end else begin
                            j_reg     <= j_reg + NDIM_W'(1);
                            state_reg <= ST_M_GO;
                        end
                    end
                end
                ST_DONE: begin
                    m_valid_reg <= 1'b1;
                    state_reg   <= ST_IDLE;
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_result_kind = m_kind_reg;
    assign m_coord_out   = m_coord_reg;
    assign m_cluster_out = m_cluster_reg;

endmodule

>>> rtl/kce_cell.sv
// ----------------------------------------------------------------------------
// kce_cell
// One cluster cell: centroid, running sums and count, distance accumulator,
// and one stage of the nearest-centroid compare chain.
// ----------------------------------------------------------------------------
module kce_cell
    import kce_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [CIDX_W-1:0]  cell_id,
    input  cell_ctrl_t         ctrl,
    input  cand_t              cand_in,
    output cand_t              cand_out,
    output coord_vec_t         cent,
    output sum_vec_t           sums,
    output logic [CNT_W-1:0]   count
);

    coord_vec_t          cent_reg;
    sum_vec_t            sum_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [SQ_W-1:0]     sq_reg;
    logic [DIST_W-1:0]   dist_reg;
    cand_t               cand_reg;

    logic signed [COORD_W:0] diff;
    logic signed [SQ_W-1:0]  sq_next;
    logic                    active;

    assign diff    = $signed({cent_reg[ctrl.dim][COORD_W-1], cent_reg[ctrl.dim]})
                   - $signed({ctrl.x[COORD_W-1], ctrl.x});
    assign sq_next = diff * diff;
    assign active  = {1'b0, cell_id} < ctrl.k;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cent_reg  <= '0;
            sum_reg   <= '0;
            count_reg <= '0;
            cand_reg  <= '0;
            dist_reg  <= '0;
            sq_reg    <= '0;
        end else begin
            if (ctrl.mul_en) begin
                sq_reg <= SQ_W'(sq_next);
            end
            if (ctrl.acc_clr) begin
                dist_reg <= '0;
            end else if (ctrl.acc_en) begin
                dist_reg <= dist_reg + DIST_W'(sq_reg);
            end
            if (ctrl.cw_en && ctrl.cw_idx == cell_id) begin
                cent_reg[ctrl.cw_dim] <= ctrl.cw_data;
            end
            if (ctrl.clr_sums) begin
                sum_reg   <= '0;
                count_reg <= '0;
            end else if (ctrl.upd_en && ctrl.upd_idx == cell_id) begin
                for (int j = 0; j < MAX_DIMS; j++) begin
                    if (NDIM_W'(j) < ctrl.d) begin
                        sum_reg[j] <= sum_reg[j]
                            + SUM_W'($signed(ctrl.pt[j]));
                    end
                end
                count_reg <= count_reg + CNT_W'(1);
            end
            // compare stage: strict less keeps ties at the lower index
            cand_reg.valid <= cand_in.valid;
            if (cand_in.valid && active && dist_reg < cand_in.score) begin
                cand_reg.score <= dist_reg;
                cand_reg.idx   <= cell_id;
            end else begin
                cand_reg.score <= cand_in.score;
                cand_reg.idx   <= cand_in.idx;
            end
        end
    end

    assign cand_out = cand_reg;
    assign cent     = cent_reg;
    assign sums     = sum_reg;
    assign count    = count_reg;

endmodule

>>> rtl/kce_div.sv
// ----------------------------------------------------------------------------
// kce_div
// Radix-2 restoring divider: signed sum over unsigned count, truncated
// toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kce_div
    import kce_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [SUM_W-1:0]    dividend,
    input  logic [CNT_W-1:0]    divisor,
    output logic                done,
    output logic [COORD_W-1:0]  quotient
);

    localparam int MAG_W  = SUM_W - 1;
    localparam int STEP_W = $clog2(MAG_W + 1);

    logic [MAG_W-1:0]   quo_reg;
    logic [CNT_W-1:0]   rem_reg;
    logic [CNT_W-1:0]   dvs_reg;
    logic               neg_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [COORD_W-1:0] q_reg;

    logic [SUM_W-1:0]   mag;
    logic [CNT_W:0]     rem_sh;
    logic               bit_ok;
    logic [MAG_W-1:0]   quo_next;

    assign mag      = dividend[SUM_W-1] ? (~dividend + SUM_W'(1)) : dividend;
    assign rem_sh   = {rem_reg, quo_reg[MAG_W-1]};
    assign bit_ok   = rem_sh >= {1'b0, dvs_reg};
    assign quo_next = {quo_reg[MAG_W-2:0], bit_ok};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                quo_reg  <= mag[MAG_W-1:0];
                rem_reg  <= '0;
                dvs_reg  <= divisor;
                neg_reg  <= dividend[SUM_W-1];
                step_reg <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg  <= bit_ok ? CNT_W'(rem_sh - {1'b0, dvs_reg}) : rem_sh[CNT_W-1:0];
                quo_reg  <= quo_next;
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(MAG_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    q_reg    <= neg_reg ? COORD_W'(~quo_next + MAG_W'(1))
                                        : COORD_W'(quo_next);
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule
